/* hdl/rcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg: shared definitions for the pulse capture and servo mixer
// Widths, command and register codes, reset values and the configuration
// record that the mixer reads.
// ----------------------------------------------------------------------------
package rcm_pkg;

  // Field widths.
  localparam int VALUE_W    = 16;
  localparam int CHANNEL_W  = 3;
  localparam int LIMIT_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default channel count, and the sweep speed divisor as a shift (divide by 16).
  localparam int NUM_CHANNELS_DEFAULT = 6;
  localparam int SWEEP_SHIFT          = 4;

  typedef logic [VALUE_W-1:0] value_t;

  // Item commands.
  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_POLL    = 1'b1
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_VALUE = 3'd0,
    CFG_SWEEP_BASE   = 3'd1,
    CFG_SWEEP_LIMIT  = 3'd2,
    CFG_SWITCH_LOW   = 3'd3,
    CFG_SWITCH_HIGH  = 3'd4
  } cfg_index_t;

  // Reset values of the configuration registers.
  localparam int CENTER_RESET      = 8450;
  localparam int SWEEP_BASE_RESET  = 6500;
  localparam int SWEEP_LIMIT_RESET = 2000;
  localparam int SWITCH_LOW_RESET  = (9160 + 6310) / 2;
  localparam int SWITCH_HIGH_RESET = (12000 + 9160) / 2;

  // Configuration record handed to the mixer.
  typedef struct packed {
    value_t               center_value;
    value_t               sweep_base;
    logic [LIMIT_W-1:0]   sweep_limit;
    value_t               switch_low_threshold;
    value_t               switch_high_threshold;
  } rcm_cfg_t;

endpackage

/* hdl/rcm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_in_if / rcm_out_if: valid/ready channels of the pulse capture mixer
// The input channel carries capture and poll beats, the output channel
// carries one result beat per poll.
// ----------------------------------------------------------------------------
interface rcm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  channel;
  logic [15:0] capture_value;

  modport source (output valid, output cmd, output channel, output capture_value,
                  input ready);
  modport sink   (input valid, input cmd, input channel, input capture_value,
                  output ready);
endinterface

interface rcm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] servo_compare;
  logic [15:0] width_ch0;
  logic [15:0] width_ch1;
  logic [15:0] width_ch2;
  logic [15:0] width_ch3;
  logic [15:0] width_ch4;
  logic [15:0] width_ch5;

  modport source (output valid, output servo_compare, output width_ch0,
                  output width_ch1, output width_ch2, output width_ch3,
                  output width_ch4, output width_ch5, input ready);
  modport sink   (input valid, input servo_compare, input width_ch0,
                  input width_ch1, input width_ch2, input width_ch3,
                  input width_ch4, input width_ch5, output ready);
endinterface

/* hdl/rcm_width_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_width_capture: per-channel pulse width measurement
// Each channel keeps its last capture count, its edge polarity and its
// measured width; a capture on a channel toggles the polarity and, when the
// polarity was clear, stores the difference to the previous capture.
// ----------------------------------------------------------------------------
module rcm_width_capture
  import rcm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 capture_en,
  input  logic [CHANNEL_W-1:0] channel,
  input  value_t               capture_value,
  output value_t               widths [NUM_CHANNELS]
);

  value_t previous_capture [NUM_CHANNELS];
  logic   edge_polarity    [NUM_CHANNELS];

  // One lane per channel; a channel number past the last lane matches none.
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    logic hit;
    assign hit = capture_en && (32'(channel) == c);

    always_ff @(posedge clk) begin
      if (rst) begin
        widths[c]           <= '0;
        previous_capture[c] <= '0;
        edge_polarity[c]    <= 1'b1;
      end else if (hit) begin
        if (!edge_polarity[c]) begin
          widths[c] <= capture_value - previous_capture[c];
        end
        edge_polarity[c]    <= !edge_polarity[c];
        previous_capture[c] <= capture_value;
      end
    end
  end

endmodule

/* hdl/rcm_servo_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_servo_mixer: mode selection, sweep generator and compare value
// Channel 4 selects reverse, sweep or pass-through for channel 0; the sweep
// position advances on each poll in sweep mode at a speed set by channel 5.
// ----------------------------------------------------------------------------
module rcm_servo_mixer
  import rcm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     poll_en,
  input  rcm_cfg_t cfg,
  input  value_t   width_ch0,
  input  value_t   width_ch4,
  input  value_t   width_ch5,
  output value_t   servo_compare
);

  value_t sweep_position;
  logic   sweep_direction;

  logic   mode_reverse;
  logic   mode_sweep;
  value_t excess;
  value_t step;
  value_t signed_step;
  value_t position_next;
  logic   above_limit;
  logic   below_limit;

  // Mode from channel 4; the low threshold is tested first.
  always_comb begin
    mode_reverse = (width_ch4 <= cfg.switch_low_threshold);
    mode_sweep   = !mode_reverse && (width_ch4 <= cfg.switch_high_threshold);
  end

  // Sweep step: channel 5 above base, divided by 16, signed by direction.
  always_comb begin
    excess        = (width_ch5 > cfg.sweep_base) ? (width_ch5 - cfg.sweep_base) : '0;
    step          = excess >> SWEEP_SHIFT;
    signed_step   = sweep_direction ? step : (VALUE_W'(0) - step);
    position_next = sweep_position + signed_step;
    above_limit   = $signed({position_next[VALUE_W-1], position_next}) >
                    $signed({2'b00, cfg.sweep_limit});
    below_limit   = $signed({position_next[VALUE_W-1], position_next}) <
                    -$signed({2'b00, cfg.sweep_limit});
  end

  // Compare value: reverse mirrors channel 0 about the centre, sweep adds
  // the new position to the centre, pass-through is channel 0 itself.
  always_comb begin
    if (mode_reverse) begin
      servo_compare = (cfg.center_value << 1) - width_ch0;
    end else if (mode_sweep) begin
      servo_compare = cfg.center_value + position_next;
    end else begin
      servo_compare = width_ch0;
    end
  end

  // Sweep state advances only on a poll in sweep mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_position  <= '0;
      sweep_direction <= 1'b1;
    end else if (poll_en && mode_sweep) begin
      sweep_position <= position_next;
      if (above_limit) begin
        sweep_direction <= 1'b0;
      end else if (below_limit) begin
        sweep_direction <= 1'b1;
      end
    end
  end

endmodule

/* hdl/rc_pulse_capture_servo_mixer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_capture_servo_mixer_core: RC pulse measurer with servo mixer
// Top level: input register, width capture lanes, mixer, result register.
// ----------------------------------------------------------------------------
// Takes one beat per clock while no poll waits for the result slot. A beat is
// held in the input register from the edge that accepts it; a capture is
// processed in the cycle that follows, a poll once the result slot is free. A
// capture updates its channel's width and yields nothing. A poll loads the
// result register with the compare value and the six widths when processed.
// While a result waits to be taken, one further beat can be accepted, and
// captures keep flowing past the waiting result. Writes to the configuration
// registers are taken at once and must be made while the block holds no beat.
module rc_pulse_capture_servo_mixer_core
  import rcm_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rcm_in_if.sink                item_in,
  rcm_out_if.source             result_out
);

  rcm_cfg_t cfg;

  // Input register.
  logic                 s1_valid;
  logic                 s1_cmd;
  logic [CHANNEL_W-1:0] s1_channel;
  value_t               s1_capture_value;

  logic   proc;
  logic   out_free;
  logic   capture_en;
  logic   poll_en;
  value_t widths [NUM_CHANNELS];
  value_t servo_compare;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_value          <= VALUE_W'(CENTER_RESET);
      cfg.sweep_base            <= VALUE_W'(SWEEP_BASE_RESET);
      cfg.sweep_limit           <= LIMIT_W'(SWEEP_LIMIT_RESET);
      cfg.switch_low_threshold  <= VALUE_W'(SWITCH_LOW_RESET);
      cfg.switch_high_threshold <= VALUE_W'(SWITCH_HIGH_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_VALUE: cfg.center_value          <= cfg_data;
        CFG_SWEEP_BASE:   cfg.sweep_base            <= cfg_data;
        CFG_SWEEP_LIMIT:  cfg.sweep_limit           <= cfg_data[LIMIT_W-1:0];
        CFG_SWITCH_LOW:   cfg.switch_low_threshold  <= cfg_data;
        CFG_SWITCH_HIGH:  cfg.switch_high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control: a capture always proceeds, a poll needs the result slot.
  always_comb begin
    out_free      = !result_out.valid || result_out.ready;
    proc          = s1_valid && ((s1_cmd == CMD_CAPTURE) || out_free);
    capture_en    = proc && (s1_cmd == CMD_CAPTURE);
    poll_en       = proc && (s1_cmd == CMD_POLL);
    item_in.ready = !s1_valid || proc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      s1_cmd           <= item_in.cmd;
      s1_channel       <= item_in.channel;
      s1_capture_value <= item_in.capture_value;
    end
  end

  rcm_width_capture #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_width_capture (
    .clk           (clk),
    .rst           (rst),
    .capture_en    (capture_en),
    .channel       (s1_channel),
    .capture_value (s1_capture_value),
    .widths        (widths)
  );

  rcm_servo_mixer u_servo_mixer (
    .clk           (clk),
    .rst           (rst),
    .poll_en       (poll_en),
    .cfg           (cfg),
    .width_ch0     (widths[0]),
    .width_ch4     (widths[4]),
    .width_ch5     (widths[5]),
    .servo_compare (servo_compare)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (poll_en) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_en) begin
      result_out.servo_compare <= servo_compare;
      result_out.width_ch0     <= widths[0];
      result_out.width_ch1     <= widths[1];
      result_out.width_ch2     <= widths[2];
      result_out.width_ch3     <= widths[3];
      result_out.width_ch4     <= widths[4];
      result_out.width_ch5     <= widths[5];
    end
  end

  // A result beat only ever follows a processed poll.
  a_result_from_poll: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(poll_en))
    else $error("result raised without a processed poll");

  // A processed poll always leaves a result waiting.
  a_poll_gives_result: assert property (@(posedge clk) disable iff (rst)
    poll_en |=> result_out.valid)
    else $error("processed poll left no result");

  // A held beat in the input register is kept until it is processed.
  a_held_beat_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !proc) |=> (s1_valid && $stable(s1_cmd) && $stable(s1_capture_value)))
    else $error("held input beat lost or changed");

endmodule
